// ===== rtl/kvst_pkg.sv =====
// Shared types and constants for the key/value bucket sum table.
// Used by kvst_bucket_mod and key_value_sum_table; no dependencies.
`default_nettype none

package kvst_pkg;

   localparam int KEY_W       = 32;
   localparam int VALUE_W     = 32;
   localparam int SUM_W       = 64;
   localparam int COUNT_W     = 64;
   localparam int INDEX_OUT_W = 10;

   // Request operation codes
   typedef enum logic {
      FUNC_ACCUMULATE = 1'b0,
      FUNC_READ       = 1'b1
   } func_type;

   // Side fields that ride along with the key through the bucket pipeline
   typedef struct packed {
      func_type             func;
      logic [VALUE_W-1:0]   value;
      logic                 last;
   } item_type;

endpackage : kvst_pkg

`default_nettype wire

// ===== rtl/kvst_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies. A read and a write to the same address return the old data.
`default_nettype none

module kvst_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                     wdata,
   input  wire logic                                 re,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output      logic [WIDTH-1:0]                     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule : kvst_ram

`default_nettype wire

// ===== rtl/kvst_bucket_mod.sv =====
// Three-stage pipeline that reduces a 32-bit key modulo a constant table size.
// Uses kvst_pkg. Quotient estimate by reciprocal multiply, then one correction step.
`default_nettype none

module kvst_bucket_mod
   import kvst_pkg::*;
#(
   parameter int DIVISOR = 1024
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       enable,
   input  wire logic                                       in_valid,
   input  wire logic [KEY_W-1:0]                           in_key,
   input  wire item_type                                   in_item,
   output      logic                                       out_valid,
   output      logic [(DIVISOR > 1 ? $clog2(DIVISOR) : 1)-1:0] out_bucket,
   output      item_type                                   out_item
);

   localparam int IDX_W = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
   localparam int REM_W = IDX_W + 1;
   localparam int RECIP_W = KEY_W + 1;
   localparam int DIV_W = IDX_W + 1;
   // floor(2^32 / D): the estimate is the true quotient or one below it
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << KEY_W) / DIVISOR);
   localparam logic [DIV_W-1:0]   DIV_C = DIV_W'(DIVISOR);
   localparam logic [REM_W-1:0]   DIV_R = REM_W'(DIVISOR);

   logic                  v1_ff, v2_ff, v3_ff;
   logic [2*KEY_W-1:0]    prod_ff;
   logic [KEY_W-1:0]      key1_ff;
   item_type              item1_ff, item2_ff, item3_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [IDX_W-1:0]      bucket_ff;

   logic [KEY_W-1:0]      quot_est;
   logic [KEY_W-1:0]      quot_times_d;
   logic [REM_W-1:0]      rem_in;
   logic [IDX_W-1:0]      bucket_in;

   // Stage 2: remainder estimate, below twice the divisor
   always_comb begin
      quot_est     = prod_ff[2*KEY_W-1:KEY_W];
      quot_times_d = KEY_W'(quot_est * DIV_C);
      rem_in       = REM_W'(key1_ff - quot_times_d);
   end

   // Stage 3: single compare and subtract
   always_comb begin
      if (rem_ff >= DIV_R) begin
         bucket_in = IDX_W'(rem_ff - DIV_R);
      end else begin
         bucket_in = IDX_W'(rem_ff);
      end
   end

   // Valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff   <= (2*KEY_W)'(in_key * RECIP);
         key1_ff   <= in_key;
         item1_ff  <= in_item;
         rem_ff    <= rem_in;
         item2_ff  <= item1_ff;
         bucket_ff <= bucket_in;
         item3_ff  <= item2_ff;
      end
   end

   assign out_valid  = v3_ff;
   assign out_bucket = bucket_ff;
   assign out_item   = item3_ff;

endmodule : kvst_bucket_mod

`default_nettype wire

// ===== rtl/key_value_sum_table.sv =====
// Key/value bucket sum table. Each request picks bucket = key mod TABLE_ENTRIES;
// an accumulate request adds its 32-bit value to that bucket's 64-bit sum (wrapping)
// and, when marked last of packet, bumps the 64-bit packet counter; a read request
// changes nothing. Each request returns one response with the bucket (low 10 bits),
// its sum and the packet total after the request. One request is taken per clock
// while req_stall is low. The reciprocal multiply is registered at acceptance, then
// remainder, correction, RAM read and the add with write-back are each registered in
// turn, with the last written bucket forwarded to a following request that hits the
// same bucket. A response stall while rsp_valid is high holds the whole pipeline.
// After reset the sum RAM is cleared one entry per cycle, with req_stall held high
// throughout. Uses kvst_pkg, kvst_bucket_mod and kvst_ram.
`default_nettype none

module key_value_sum_table
   import kvst_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic                   req_func,
   input  wire logic [KEY_W-1:0]       req_pair_key,
   input  wire logic [VALUE_W-1:0]     req_pair_value,
   input  wire logic                   req_last_of_packet,
   // response channel
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [INDEX_OUT_W-1:0] rsp_bucket_index,
   output      logic [SUM_W-1:0]       rsp_bucket_sum,
   output      logic [COUNT_W-1:0]     rsp_packet_total
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(TABLE_ENTRIES - 1);

   logic                   advance;
   item_type               req_item;

   logic                   mod_valid;
   logic [IDX_W-1:0]       mod_bucket;
   item_type               mod_item;

   logic                   clr_active_ff;
   logic [IDX_W-1:0]       clr_addr_ff;

   logic                   x_valid_ff;
   logic [IDX_W-1:0]       x_bucket_ff;
   item_type               x_item_ff;
   logic [SUM_W-1:0]       ram_rdata;

   logic                   fwd_valid_ff;
   logic [IDX_W-1:0]       fwd_idx_ff;
   logic [SUM_W-1:0]       fwd_sum_ff;

   logic [COUNT_W-1:0]     count_ff;
   logic [COUNT_W-1:0]     count_in;

   logic                   rsp_valid_ff;
   logic [INDEX_OUT_W-1:0] rsp_index_ff;
   logic [SUM_W-1:0]       rsp_sum_ff;
   logic [COUNT_W-1:0]     rsp_total_ff;

   logic                   x_acc;
   logic [SUM_W-1:0]       base_sum;
   logic [SUM_W-1:0]       sum_in;

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   logic [SUM_W-1:0]       ram_wdata;

   // Pipeline moves whenever the response register is free or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = clr_active_ff || !advance;

   always_comb begin
      req_item.func  = func_type'(req_func);
      req_item.value = req_pair_value;
      req_item.last  = req_last_of_packet;
   end

   kvst_bucket_mod #(
      .DIVISOR (TABLE_ENTRIES)
   ) u_bucket_mod (
      .clock      (clock),
      .reset      (reset),
      .enable     (advance),
      .in_valid   (req_valid && !clr_active_ff),
      .in_key     (req_pair_key),
      .in_item    (req_item),
      .out_valid  (mod_valid),
      .out_bucket (mod_bucket),
      .out_item   (mod_item)
   );

   // Post-reset clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         if (clr_addr_ff == LAST_ENTRY) begin
            clr_active_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + IDX_W'(1);
      end
   end

   // Read-modify-write stage; forward the previous write on a bucket match
   always_comb begin
      x_acc = (x_item_ff.func == FUNC_ACCUMULATE);
      if (fwd_valid_ff && (fwd_idx_ff == x_bucket_ff)) begin
         base_sum = fwd_sum_ff;
      end else begin
         base_sum = ram_rdata;
      end
      if (x_acc) begin
         sum_in   = base_sum + SUM_W'(x_item_ff.value);
         count_in = count_ff + COUNT_W'(x_item_ff.last);
      end else begin
         sum_in   = base_sum;
         count_in = count_ff;
      end
   end

   // Write port: clearing sweep, else the accumulate write-back
   always_comb begin
      if (clr_active_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = advance && x_valid_ff && x_acc;
         ram_waddr = x_bucket_ff;
         ram_wdata = sum_in;
      end
   end

   kvst_ram #(
      .WIDTH (SUM_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_sum_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (advance),
      .raddr (mod_bucket),
      .rdata (ram_rdata)
   );

   // Control state of the back end
   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else if (advance) begin
         x_valid_ff   <= mod_valid;
         fwd_valid_ff <= x_valid_ff && x_acc;
         rsp_valid_ff <= x_valid_ff;
         if (x_valid_ff) begin
            count_ff <= count_in;
         end
      end
   end

   // Back-end payload
   always_ff @(posedge clock) begin
      if (advance) begin
         x_bucket_ff <= mod_bucket;
         x_item_ff   <= mod_item;
         fwd_idx_ff  <= x_bucket_ff;
         fwd_sum_ff  <= sum_in;
         if (x_valid_ff) begin
            rsp_index_ff <= INDEX_OUT_W'(x_bucket_ff);
            rsp_sum_ff   <= sum_in;
            rsp_total_ff <= count_in;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bucket_index = rsp_index_ff;
   assign rsp_bucket_sum   = rsp_sum_ff;
   assign rsp_packet_total = rsp_total_ff;

   // Pipeline is empty when the clearing sweep ends
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_active_ff) |-> (!x_valid_ff && !rsp_valid_ff && !mod_valid))
      else $error("request in flight during table clear");

   // Packet counter only moves when the pipeline advances
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(count_ff))
      else $error("packet counter changed while stalled");

   // Every accumulate write-back is captured for forwarding; a forwarded sum always comes from one
   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      (advance && x_valid_ff && x_acc && !clr_active_ff) |=> fwd_valid_ff)
      else $error("write-back not captured for forwarding");

endmodule : key_value_sum_table

`default_nettype wire
